/* rtl/ttsg_pkg.sv */
// Shared types, codes and lookup functions for the three-tone, one-noise sound generator.
`timescale 1ns / 1ps

package ttsg_pkg;

	localparam int NUM_TONE = 3;
	localparam int NUM_CHAN = 4;

	// Request kinds carried on the input stream.
	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_STEREO = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// Configuration register indexes.
	localparam logic [0:0] CFG_TAP_MASK = 1'b0;
	localparam logic [0:0] CFG_FEED_POS = 1'b1;

	localparam logic [1:0]  NOISE_CH       = 2'd3;
	localparam logic [15:0] TAP_MASK_RESET = 16'd9;
	localparam logic [3:0]  FEED_POS_RESET = 4'd15;

	typedef logic [9:0]         period_t;
	typedef logic [10:0]        count_t;
	typedef logic [3:0]         atten_t;
	typedef logic signed [14:0] level_t;
	typedef logic signed [16:0] mix_t;

	// Architectural state that the level stage reads.
	typedef struct packed {
		period_t [NUM_TONE-1:0] period;
		atten_t  [NUM_CHAN-1:0] att;
		logic    [NUM_CHAN-1:0] pol;
		logic    [NUM_CHAN-1:0] left_en;
		logic    [NUM_CHAN-1:0] right_en;
		logic    [15:0]         sr;
		logic                   white;
		logic    [1:0]          rate;
		logic                   toggle;
	} ttsg_state_t;

	// Magnitude for each attenuation step, 2 dB apart, last step silent.
	function automatic logic [13:0] atten_mag(atten_t a);
		logic [13:0] m;
		case (a)
			4'd0:    m = 14'd16383;
			4'd1:    m = 14'd13014;
			4'd2:    m = 14'd10337;
			4'd3:    m = 14'd8211;
			4'd4:    m = 14'd6522;
			4'd5:    m = 14'd5181;
			4'd6:    m = 14'd4115;
			4'd7:    m = 14'd3284;
			4'd8:    m = 14'd2596;
			4'd9:    m = 14'd2062;
			4'd10:   m = 14'd1638;
			4'd11:   m = 14'd1301;
			4'd12:   m = 14'd1033;
			4'd13:   m = 14'd821;
			4'd14:   m = 14'd652;
			default: m = 14'd0;
		endcase
		return m;
	endfunction

	// Noise channel period: three fixed rates or the period of tone channel two.
	function automatic period_t noise_period(logic [1:0] rate, period_t tp2);
		period_t p;
		case (rate)
			2'd0:    p = 10'd16;
			2'd1:    p = 10'd32;
			2'd2:    p = 10'd64;
			default: p = tp2;
		endcase
		return p;
	endfunction

	// Period of any channel taken from the current state.
	function automatic period_t chan_period(ttsg_state_t st, logic [1:0] ch);
		period_t p;
		if (ch == NOISE_CH) begin
			p = noise_period(st.rate, st.period[2]);
		end else begin
			p = st.period[ch];
		end
		return p;
	endfunction

	function automatic level_t chan_level(atten_t a, logic positive);
		level_t mag;
		mag = level_t'({1'b0, atten_mag(a)});
		return positive ? mag : -mag;
	endfunction

endpackage

/* rtl/ttsg_state.sv */
// Channel state registers of the sound generator and their update on each request.
`timescale 1ns / 1ps

module ttsg_state (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  acc,
	input  ttsg_pkg::action_t     action,
	input  logic [7:0]            data,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [15:0]           cfg_wdata,
	output ttsg_pkg::ttsg_state_t st
);
	import ttsg_pkg::*;

	ttsg_state_t st_q, st_nxt;
	count_t      cnt_q [NUM_CHAN];
	count_t      cnt_nxt [NUM_CHAN];
	logic [1:0]  sel_ch_q, sel_ch_nxt;
	logic        sel_vol_q, sel_vol_nxt;
	logic [15:0] tap_mask_q;
	logic [3:0]  feed_pos_q;

	logic        latch;
	logic [5:0]  d;
	logic [1:0]  ch;
	logic        vol;
	period_t     p [NUM_CHAN];
	logic        expire [NUM_CHAN];
	logic        fb;
	logic [15:0] sr_shift;

	assign latch = data[7];
	assign d     = latch ? {2'b00, data[3:0]} : data[5:0];
	assign ch    = latch ? data[6:5] : sel_ch_q;
	assign vol   = latch ? data[4] : sel_vol_q;

	// Next value of the noise shift register when it clocks.
	assign fb       = st_q.white ? ^(st_q.sr & tap_mask_q) : st_q.sr[0];
	assign sr_shift = (st_q.sr >> 1) | (16'(fb) << feed_pos_q);

	always_comb begin
		for (int i = 0; i < NUM_CHAN; i++) begin
			p[i]      = chan_period(st_q, 2'(i));
			expire[i] = (p[i][9:1] != '0) && (cnt_q[i][10:1] == '0);
		end
	end

	always_comb begin
		st_nxt      = st_q;
		sel_ch_nxt  = sel_ch_q;
		sel_vol_nxt = sel_vol_q;
		for (int i = 0; i < NUM_CHAN; i++) begin
			cnt_nxt[i] = cnt_q[i];
		end
		if (acc) begin
			case (action)
				ACT_WRITE: begin
					sel_ch_nxt  = ch;
					sel_vol_nxt = vol;
					if (vol) begin
						st_nxt.att[ch] = d[3:0];
					end else if (ch != NOISE_CH) begin
						if (latch) begin
							st_nxt.period[ch][3:0] = d[3:0];
						end else begin
							st_nxt.period[ch][9:4] = d;
						end
					end else begin
						// Noise control write restarts the shift register.
						st_nxt.rate   = d[1:0];
						st_nxt.white  = d[2];
						st_nxt.sr     = 16'd1 << feed_pos_q;
						st_nxt.toggle = 1'b1;
					end
				end
				ACT_STEREO: begin
					st_nxt.left_en  = data[7:4];
					st_nxt.right_en = data[3:0];
				end
				ACT_TICK: begin
					for (int i = 0; i < NUM_CHAN; i++) begin
						if (p[i][9:1] != '0) begin
							if (expire[i]) begin
								cnt_nxt[i] = cnt_q[i] + count_t'(p[i]) - 11'd1;
							end else begin
								cnt_nxt[i] = cnt_q[i] - 11'd1;
							end
						end
					end
					for (int i = 0; i < NUM_TONE; i++) begin
						if (expire[i]) begin
							st_nxt.pol[i] = ~st_q.pol[i];
						end
					end
					if (expire[NUM_CHAN-1]) begin
						st_nxt.toggle = ~st_q.toggle;
						if (!st_q.toggle) begin
							st_nxt.sr                = sr_shift;
							st_nxt.pol[NUM_CHAN-1]   = sr_shift[0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TONE; i++) begin
				st_q.period[i] <= '0;
			end
			for (int i = 0; i < NUM_CHAN; i++) begin
				st_q.att[i] <= 4'd15;
				cnt_q[i]    <= '0;
			end
			st_q.pol      <= '1;
			st_q.left_en  <= '1;
			st_q.right_en <= '1;
			st_q.sr       <= 16'd1 << FEED_POS_RESET;
			st_q.white    <= 1'b0;
			st_q.rate     <= 2'd0;
			st_q.toggle   <= 1'b1;
			sel_ch_q      <= 2'd0;
			sel_vol_q     <= 1'b0;
		end else begin
			st_q      <= st_nxt;
			sel_ch_q  <= sel_ch_nxt;
			sel_vol_q <= sel_vol_nxt;
			for (int i = 0; i < NUM_CHAN; i++) begin
				cnt_q[i] <= cnt_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_mask_q <= TAP_MASK_RESET;
			feed_pos_q <= FEED_POS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TAP_MASK: tap_mask_q <= cfg_wdata;
				CFG_FEED_POS: feed_pos_q <= cfg_wdata[3:0];
				default: begin
				end
			endcase
		end
	end

	assign st = st_q;

	// The state only moves on an accepted request.
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(st_q))
		else $error("channel state changed without a request");

	a_none_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc && action == ACT_NONE |=> $stable(st_q))
		else $error("unused request kind changed the channel state");

	a_stereo: assert property (@(posedge clk) disable iff (!arst_n)
		acc && action == ACT_STEREO |=>
			st_q.left_en == $past(data[7:4]) && st_q.right_en == $past(data[3:0]))
		else $error("stereo enables do not follow the written byte");

endmodule

/* rtl/three_tone_one_noise_sound_generator_core.sv */
// Top level of the three-tone, one-noise sound generator with stream ports.
`timescale 1ns / 1ps

// Throughput: one request per cycle; the channel state, level and mix registers form a
// three-stage pipeline that only backs up when m_tready is held low.
// Reset: arst_n asynchronously clears the channel state to the power-up sound state (silent
// attenuation, zero periods, both sides enabled) and restores the noise tap mask and feed bit.
module three_tone_one_noise_sound_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	// Input requests.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] action
	// Results.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [14:0] tone0_level, [29:15] tone1_level,
	                               // [44:30] tone2_level, [59:45] noise_level,
	                               // [76:60] left_mix, [93:77] right_mix,
	                               // [94] noise_bit, [95] zero
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import ttsg_pkg::*;

	ttsg_state_t st;
	logic        acc;
	action_t     action;

	// Pipeline occupancy: s1 means the state registers hold an update whose levels
	// are not yet taken, s2 holds the channel levels, the output holds the mixes.
	logic        valid_s1;
	logic        valid_s2;
	logic        m_valid_q;
	logic        out_ready;
	logic        s2_ready;
	logic        s2_load;

	level_t      lvl_s2 [NUM_CHAN];
	logic [3:0]  left_s2;
	logic [3:0]  right_s2;
	logic        nbit_s2;

	level_t      lvl_q [NUM_CHAN];
	mix_t        lmix_q;
	mix_t        rmix_q;
	logic        nbit_q;

	mix_t        lmix;
	mix_t        rmix;

	assign out_ready = !m_valid_q || m_tready;
	assign s2_ready  = !valid_s2 || out_ready;
	assign s_tready  = !valid_s1 || s2_ready;
	assign acc       = s_tvalid && s_tready;
	assign action    = action_t'(s_tuser);
	assign s2_load   = valid_s1 && s2_ready;

	ttsg_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.action    (action),
		.data      (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.st        (st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s2_ready) begin
				valid_s1 <= 1'b0;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (out_ready) begin
				m_valid_q <= valid_s2;
			end
		end
	end

	// Level stage: a channel with a period of 0 or 1 sits at the positive level,
	// otherwise its polarity picks the sign of the attenuation magnitude.
	always_ff @(posedge clk) begin
		if (s2_load) begin
			for (int i = 0; i < NUM_CHAN; i++) begin
				lvl_s2[i] <= chan_level(st.att[i],
					(chan_period(st, 2'(i)) <= 10'd1) || st.pol[i]);
			end
			left_s2  <= st.left_en;
			right_s2 <= st.right_en;
			nbit_s2  <= st.sr[0];
		end
	end

	// Mix stage: sum the enabled levels for each side.
	always_comb begin
		lmix = '0;
		rmix = '0;
		for (int i = 0; i < NUM_CHAN; i++) begin
			if (left_s2[i]) begin
				lmix = lmix + mix_t'(lvl_s2[i]);
			end
			if (right_s2[i]) begin
				rmix = rmix + mix_t'(lvl_s2[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			for (int i = 0; i < NUM_CHAN; i++) begin
				lvl_q[i] <= lvl_s2[i];
			end
			lmix_q <= lmix;
			rmix_q <= rmix;
			nbit_q <= nbit_s2;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, nbit_q, rmix_q, lmix_q, lvl_q[3], lvl_q[2], lvl_q[1], lvl_q[0]};

	// A pending state update always reaches the level stage once there is room.
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		s2_load |=> valid_s2)
		else $error("level stage did not take a pending update");

	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_ready |=> m_valid_q)
		else $error("output register did not take the mixed levels");

	// Requests are only refused when every stage is full and the output is stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && m_valid_q && !m_tready)
		else $error("input refused while the pipeline has room");

endmodule

/* tb/sv/three_tone_one_noise_sound_generator_core_test.sv */
// Stream testbench for the sound generator core: a directed table, then randomized requests.
`timescale 1ns / 1ps

module three_tone_one_noise_sound_generator_core_test;
	import ttsg_pkg::*;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [95:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	three_tone_one_noise_sound_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// One output sample, laid out as m_tdata[94:0] with tone0 in the lowest bits.
	typedef struct packed {
		logic   nbit;
		mix_t   right;
		mix_t   left;
		level_t noise;
		level_t tone2;
		level_t tone1;
		level_t tone0;
	} sound_sample_t;

	// A row of the directed table; the level fields only count when typed is set.
	typedef struct {
		action_t    act;
		logic [7:0] data;
		bit         typed;
		int         t0, t1, t2, tn, lm, rm;
		bit         nb;
	} stim_row_t;

	stim_row_t directed_rows [25] = '{
		// Power-up state: everything silent, noise register holds only its top bit.
		'{ACT_TICK,   8'h00, 1'b1, 0, 0, 0, 0, 0, 0, 1'b0},
		// Full volume on each channel in turn; zero periods hold a steady positive level.
		'{ACT_WRITE,  8'h90, 1'b1, 16383, 0, 0, 0, 16383, 16383, 1'b0},
		'{ACT_WRITE,  8'hB0, 1'b1, 16383, 16383, 0, 0, 32766, 32766, 1'b0},
		'{ACT_WRITE,  8'hD0, 1'b1, 16383, 16383, 16383, 0, 49149, 49149, 1'b0},
		'{ACT_WRITE,  8'hF0, 1'b1, 16383, 16383, 16383, 16383, 65532, 65532, 1'b0},
		// Stereo extremes.
		'{ACT_STEREO, 8'h00, 1'b1, 16383, 16383, 16383, 16383, 0, 0, 1'b0},
		'{ACT_STEREO, 8'hF0, 1'b1, 16383, 16383, 16383, 16383, 65532, 0, 1'b0},
		'{ACT_STEREO, 8'h0F, 1'b1, 16383, 16383, 16383, 16383, 0, 65532, 1'b0},
		'{ACT_STEREO, 8'hA5, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		// Tone zero at the shortest toggling period, then ticks.
		'{ACT_WRITE,  8'h82, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ACT_WRITE,  8'h00, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ACT_TICK,   8'h00, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ACT_TICK,   8'hFF, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ACT_TICK,   8'h00, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		// A period of one freezes the channel at a positive level.
		'{ACT_WRITE,  8'h81, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ACT_TICK,   8'h00, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		// Volume by latch and by a following data write.
		'{ACT_WRITE,  8'hBF, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ACT_WRITE,  8'h3F, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		// Near-largest period on tone one.
		'{ACT_WRITE,  8'hA3, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ACT_WRITE,  8'h3F, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		// White noise by latch, then rate three by a data write to the noise channel.
		'{ACT_WRITE,  8'hE4, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ACT_WRITE,  8'h07, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		// The unused action only reports the current levels.
		'{ACT_NONE,   8'hFF, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ACT_WRITE,  8'hC0, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0},
		'{ACT_TICK,   8'h00, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0}
	};

	int level_mag [16] = '{16383, 13014, 10337, 8211, 6522, 5181, 4115, 3284,
		2596, 2062, 1638, 1301, 1033, 821, 652, 0};

	// Sound state mirrored by the predictor.
	period_t     tone_per [3];
	atten_t      att      [4];
	count_t      cnt      [4];
	logic [3:0]  pol;
	logic [3:0]  left_on;
	logic [3:0]  right_on;
	logic [15:0] lfsr;
	logic        white;
	logic [1:0]  rate;
	logic        toggle;
	logic [1:0]  sel_ch;
	logic        sel_vol;
	logic [15:0] tap_mask;
	logic [3:0]  feed_pos;

	sound_sample_t pending_samples [$];
	sound_sample_t got, want;
	int failures  = 0;
	int received  = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit no_idle   = 1'b0;

	function automatic period_t period_of(int ch);
		if (ch < NUM_TONE) begin
			return tone_per[ch];
		end
		case (rate)
			2'd0:    return 10'd16;
			2'd1:    return 10'd32;
			2'd2:    return 10'd64;
			default: return tone_per[2];
		endcase
	endfunction

	// A silent or steady channel reports the positive magnitude.
	function automatic level_t level_of(int ch);
		int mag;
		mag = level_mag[att[ch]];
		if (period_of(ch) <= 1 || pol[ch]) begin
			return level_t'(mag);
		end
		return level_t'(-mag);
	endfunction

	// Advances the mirrored state by one request and forms the sample it yields.
	task automatic predict_request(input action_t act, input logic [7:0] b,
		output sound_sample_t s);
		period_t p;
		count_t  c;
		logic [5:0] d;
		logic fb;
		level_t lv [4];
		int lsum, rsum;
		lsum = 0;
		rsum = 0;
		case (act)
			ACT_WRITE: begin
				if (b[7]) begin
					sel_ch  = b[6:5];
					sel_vol = b[4];
					d = {2'b00, b[3:0]};
				end else begin
					d = b[5:0];
				end
				if (sel_vol) begin
					att[sel_ch] = d[3:0];
				end else if (sel_ch != NOISE_CH) begin
					if (b[7]) begin
						tone_per[sel_ch][3:0] = d[3:0];
					end else begin
						tone_per[sel_ch][9:4] = d;
					end
				end else begin
					// Noise writes reload the shift register but keep counter and polarity.
					rate   = d[1:0];
					white  = d[2];
					lfsr   = 16'd1 << feed_pos;
					toggle = 1'b1;
				end
			end
			ACT_STEREO: begin
				left_on  = b[7:4];
				right_on = b[3:0];
			end
			ACT_TICK: begin
				for (int ch = 0; ch < NUM_CHAN; ch++) begin
					p = period_of(ch);
					c = cnt[ch];
					if (p > 1) begin
						if (c > 1) begin
							cnt[ch] = c - 1'b1;
						end else begin
							cnt[ch] = c + count_t'(p) - 1'b1;
							if (ch < NUM_TONE) begin
								pol[ch] = ~pol[ch];
							end else begin
								// The noise register shifts on every second expiry.
								toggle = ~toggle;
								if (toggle) begin
									fb = white ? ^(lfsr & tap_mask) : lfsr[0];
									lfsr = (lfsr >> 1) | (16'(fb) << feed_pos);
									pol[3] = lfsr[0];
								end
							end
						end
					end
				end
			end
			default: ;
		endcase
		for (int ch = 0; ch < NUM_CHAN; ch++) begin
			lv[ch] = level_of(ch);
			if (left_on[ch]) begin
				lsum += lv[ch];
			end
			if (right_on[ch]) begin
				rsum += lv[ch];
			end
		end
		s.tone0 = lv[0];
		s.tone1 = lv[1];
		s.tone2 = lv[2];
		s.noise = lv[3];
		s.left  = mix_t'(lsum);
		s.right = mix_t'(rsum);
		s.nbit  = lfsr[0];
	endtask

	task automatic check_field(input string name, input logic signed [16:0] exp_val,
		input logic signed [16:0] act_val);
		if (exp_val !== act_val) begin
			failures++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
				exp_val, act_val);
		end
	endtask

	// Offers one request, after a random gap unless no_idle is set, and records its expected sample.
	task automatic send_request(input action_t act, input logic [7:0] b, input bit typed,
		input sound_sample_t typed_val);
		sound_sample_t predicted;
		if (!no_idle) begin
			while ($urandom_range(99) < 8) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		predict_request(act, b, predicted);
		pending_samples.push_back(typed ? typed_val : predicted);
	endtask

	// Stops offering and waits until every pending sample is out, plus pipeline slack.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Result side: checks each sample and drives m_tready, including one long hold-off.
	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = sound_sample_t'(m_tdata[94:0]);
				if (pending_samples.size() == 0) begin
					failures++;
					$display("%0t: sample with no pending request, expected none, actual %h",
						$time, got);
				end else begin
					want = pending_samples.pop_front();
					check_field("tone0_level", want.tone0, got.tone0);
					check_field("tone1_level", want.tone1, got.tone1);
					check_field("tone2_level", want.tone2, got.tone2);
					check_field("noise_level", want.noise, got.noise);
					check_field("left_mix", want.left, got.left);
					check_field("right_mix", want.right, got.right);
					check_field("noise_bit", want.nbit, got.nbit);
				end
				received++;
				if (received == 700 && !hold_done) begin
					hold_left = 300;
					hold_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (no_idle) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 8);
			end
		end
	end

	initial begin
		stim_row_t     row;
		sound_sample_t typed_val;
		logic [15:0]   mask;
		logic [3:0]    feed;
		logic [5:0]    d6;
		int n, k;
		bit paused;

		tap_mask = TAP_MASK_RESET;
		feed_pos = FEED_POS_RESET;
		for (int i = 0; i < NUM_TONE; i++) begin
			tone_per[i] = '0;
		end
		for (int i = 0; i < NUM_CHAN; i++) begin
			att[i] = 4'd15;
			cnt[i] = '0;
		end
		pol      = '1;
		left_on  = '1;
		right_on = '1;
		lfsr     = 16'd1 << feed_pos;
		white    = 1'b0;
		rate     = 2'd0;
		toggle   = 1'b1;
		sel_ch   = 2'd0;
		sel_vol  = 1'b0;
		paused   = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			typed_val.tone0 = level_t'(row.t0);
			typed_val.tone1 = level_t'(row.t1);
			typed_val.tone2 = level_t'(row.t2);
			typed_val.noise = level_t'(row.tn);
			typed_val.left  = mix_t'(row.lm);
			typed_val.right = mix_t'(row.rm);
			typed_val.nbit  = row.nb;
			send_request(row.act, row.data, row.typed, typed_val);
		end

		// Phase zero runs on the reset settings; later phases rewrite both registers.
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				case (ph)
					1: begin mask = 16'hFFFF; feed = 4'd0; end
					2: begin mask = 16'h0000; feed = 4'd15; end
					3: begin mask = 16'($urandom); feed = 4'($urandom); end
					default: begin mask = TAP_MASK_RESET; feed = FEED_POS_RESET; end
				endcase
				wait_drained();
				cfg_we    <= 1'b1;
				cfg_index <= CFG_TAP_MASK;
				cfg_wdata <= mask;
				@(posedge clk);
				cfg_index <= CFG_FEED_POS;
				cfg_wdata <= {12'd0, feed};
				@(posedge clk);
				cfg_we   <= 1'b0;
				tap_mask = mask;
				feed_pos = feed;
			end
			// The last phase runs without any idle cycles on either side.
			no_idle = (ph == 4);
			n = 0;
			while (n < 340) begin
				if (ph == 1 && n >= 150 && !paused) begin
					paused = 1'b1;
					wait_drained();
				end
				k = $urandom_range(99);
				if (k < 55) begin
					send_request(ACT_TICK, 8'($urandom), 1'b0, '0);
					n += 1;
				end else if (k < 70) begin
					// Latch followed by a data write; data mostly small to keep periods short.
					send_request(ACT_WRITE, {1'b1, 2'($urandom), 1'($urandom), 4'($urandom)},
						1'b0, '0);
					d6 = ($urandom_range(99) < 70) ? 6'($urandom_range(3)) : 6'($urandom);
					send_request(ACT_WRITE, {2'b00, d6}, 1'b0, '0);
					n += 2;
				end else if (k < 85) begin
					send_request(ACT_WRITE, 8'($urandom), 1'b0, '0);
					n += 1;
				end else if (k < 95) begin
					send_request(ACT_STEREO, 8'($urandom), 1'b0, '0);
					n += 1;
				end else begin
					send_request(ACT_NONE, 8'($urandom), 1'b0, '0);
					n += 1;
				end
			end
		end

		wait_drained();
		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
